@@ hw/rtl/smsd_pkg.sv @@
// shared constants, codes and controller/datapath interface types
// for the sample mean and standard deviation block; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package smsd_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 10;

    // result fields are unsigned q.8
    localparam int OUT_W      = 18;
    localparam int MEAN_FRAC  = 8;
    localparam int VAR_FRAC   = 2 * MEAN_FRAC;
    localparam int OUT_DATA_W = ((2 * OUT_W + 7) / 8) * 8;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_NQ,
        OP_MUL_SS,
        OP_MUL_NN,
        OP_DIV_MEAN,
        OP_DIV_SD,
        OP_ROOT
    } op_t;

    typedef struct packed {
        logic acc_en;
        logic start;
        op_t  op;
        logic load_out;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic root_done;
        logic n_zero;
        logic n_ge2;
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/smsd_div.sv @@
// restoring divider, one quotient bit per cycle
// uses no package
`timescale 1ns / 1ps
`default_nettype none

module smsd_div #(
    parameter int NW = 58,
    parameter int MW = 22
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [MW-1:0] divisor,
    output logic               done,
    output logic [NW-1:0]      quotient
);

    localparam int CNTW = $clog2(NW);

    logic [NW-1:0]   quo_reg;
    logic [MW-1:0]   rem_reg;
    logic [MW-1:0]   dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [MW:0]     rem_shift;
    logic [MW+1:0]   trial;

    assign rem_shift = {rem_reg, quo_reg[NW-1]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[MW+1])
            begin
                rem_reg <= trial[MW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[MW-1:0];
                quo_reg <= {quo_reg[NW-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smsd_sqrt.sv @@
// integer square root, one result bit per cycle
// uses no package
`timescale 1ns / 1ps
`default_nettype none

module smsd_sqrt #(
    parameter int NW = 58
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] operand,
    output logic               done,
    output logic [(NW+1)/2-1:0] root
);

    localparam int RW   = (NW + 1) / 2;
    localparam int VW   = 2 * RW;
    localparam int CNTW = $clog2(RW);

    logic [VW-1:0]   v_reg;
    logic [VW-1:0]   root_reg;
    logic [VW-1:0]   bit_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [VW-1:0]   trial;

    assign trial = root_reg + bit_reg;
    assign done  = done_reg;
    assign root  = root_reg[RW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // test bit walks down two places per step from the top even position
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= VW'(operand);
            root_reg <= '0;
            bit_reg  <= {2'b01, {(VW-2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg    <= v_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smsd_dp.sv @@
// datapath: accumulators, serial multiplier, divider, square root, result registers
// depends on smsd_pkg, smsd_div and smsd_sqrt
`timescale 1ns / 1ps
`default_nettype none

module smsd_dp #(
    parameter int MAX_SAMPLES = smsd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [SAMPLE_BITS-1:0] score,
    input  wire smsd_pkg::cmd_t         cmd,
    output smsd_pkg::sts_t              sts,
    output logic [smsd_pkg::OUT_W-1:0]  mean_q8,
    output logic [smsd_pkg::OUT_W-1:0]  std_dev_q8,
    output logic [smsd_pkg::STATUS_W-1:0] status
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int SW  = SAMPLE_BITS + CW;
    localparam int QW  = 2 * SAMPLE_BITS + CW;
    localparam int PW  = QW + SW;
    localparam int DW  = 2 * SW;
    localparam int MW  = 2 * CW;
    localparam int MF  = smsd_pkg::MEAN_FRAC;
    localparam int VF  = smsd_pkg::VAR_FRAC;
    localparam int NW  = DW + VF;
    localparam int RW  = (NW + 1) / 2;
    localparam int OW  = smsd_pkg::OUT_W;
    localparam int MCW = $clog2(SW);
    localparam int SQW = 2 * SAMPLE_BITS;

    logic [CW-1:0]  count_reg;
    logic [SW-1:0]  sum_reg;
    logic [QW-1:0]  sq_reg;
    logic           ovf_reg;
    logic [SQW-1:0] sq_prod;

    logic [PW-1:0]  mul_a_reg;
    logic [SW-1:0]  mul_b_reg;
    logic [PW-1:0]  mul_p_reg;
    logic [MCW-1:0] mul_cnt_reg;
    logic           mul_busy_reg;
    logic           mul_done_reg;
    logic           mul_start;
    logic [PW-1:0]  mul_a_in;
    logic [SW-1:0]  mul_b_in;

    logic [DW-1:0]  p1_reg;
    logic [DW-1:0]  d_reg;
    logic [MW-1:0]  m_reg;

    logic           div_start;
    logic [NW-1:0]  div_dividend;
    logic [MW-1:0]  div_divisor;
    logic           div_done;
    logic [NW-1:0]  div_quotient;

    logic           root_start;
    logic           root_done;
    logic [RW-1:0]  root_val;

    logic [OW-1:0]  mean_res_reg;
    logic [OW-1:0]  sd_res_reg;
    logic [OW-1:0]  mean_out_reg;
    logic [OW-1:0]  sd_out_reg;
    logic [smsd_pkg::STATUS_W-1:0] status_out_reg;
    logic [smsd_pkg::STATUS_W-1:0] status_next;

    assign sq_prod = SQW'(score) * SQW'(score);

    // running count, sum and sum of squares
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            sq_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.acc_en)
        begin
            if (count_reg < CW'(MAX_SAMPLES))
            begin
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + SW'(score);
                sq_reg    <= sq_reg + QW'(sq_prod);
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // operand selection for the shared units
    always_comb
    begin
        mul_start  = cmd.start && (cmd.op == smsd_pkg::OP_MUL_NQ ||
                                   cmd.op == smsd_pkg::OP_MUL_SS ||
                                   cmd.op == smsd_pkg::OP_MUL_NN);
        div_start  = cmd.start && (cmd.op == smsd_pkg::OP_DIV_MEAN ||
                                   cmd.op == smsd_pkg::OP_DIV_SD);
        root_start = cmd.start && (cmd.op == smsd_pkg::OP_ROOT);
        case (cmd.op)
            smsd_pkg::OP_MUL_NQ:
            begin
                mul_a_in = PW'(sq_reg);
                mul_b_in = SW'(count_reg);
            end
            smsd_pkg::OP_MUL_SS:
            begin
                mul_a_in = PW'(sum_reg);
                mul_b_in = sum_reg;
            end
            default:
            begin
                mul_a_in = PW'(count_reg);
                mul_b_in = SW'(count_reg - 1'b1);
            end
        endcase
        if (cmd.op == smsd_pkg::OP_DIV_SD)
        begin
            div_dividend = {d_reg, {VF{1'b0}}};
            div_divisor  = m_reg;
        end
        else
        begin
            div_dividend = NW'({sum_reg, {MF{1'b0}}});
            div_divisor  = MW'(count_reg);
        end
    end

    // shift-add multiplier, one multiplier bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end
        else
        begin
            mul_done_reg <= 1'b0;
            if (mul_start)
            begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end
            else if (mul_busy_reg)
            begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MCW'(SW - 1))
                begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mul_a_reg <= mul_a_in;
            mul_b_reg <= mul_b_in;
            mul_p_reg <= '0;
        end
        else if (mul_busy_reg)
        begin
            if (mul_b_reg[0])
            begin
                mul_p_reg <= mul_p_reg + mul_a_reg;
            end
            mul_a_reg <= mul_a_reg << 1;
            mul_b_reg <= mul_b_reg >> 1;
        end
    end

    // n*sumsq - sum^2 never goes negative, so the difference fits unsigned
    always_ff @(posedge clk)
    begin
        if (mul_done_reg)
        begin
            case (cmd.op)
                smsd_pkg::OP_MUL_NQ: p1_reg <= DW'(mul_p_reg);
                smsd_pkg::OP_MUL_SS: d_reg  <= p1_reg - DW'(mul_p_reg);
                smsd_pkg::OP_MUL_NN: m_reg  <= MW'(mul_p_reg);
                default:             m_reg  <= m_reg;
            endcase
        end
    end

    smsd_div #(
        .NW (NW),
        .MW (MW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    smsd_sqrt #(
        .NW (NW)
    ) u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (div_quotient),
        .done    (root_done),
        .root    (root_val)
    );

    // results of the set; zero unless the matching unit ran
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_res_reg <= '0;
            sd_res_reg   <= '0;
        end
        else if (cmd.clear)
        begin
            mean_res_reg <= '0;
            sd_res_reg   <= '0;
        end
        else
        begin
            if (div_done && cmd.op == smsd_pkg::OP_DIV_MEAN)
            begin
                mean_res_reg <= OW'(div_quotient);
            end
            if (root_done)
            begin
                sd_res_reg <= OW'(root_val);
            end
        end
    end

    always_comb
    begin
        if (ovf_reg)
        begin
            status_next = smsd_pkg::STATUS_OVERFLOW;
        end
        else if (count_reg == CW'(1))
        begin
            status_next = smsd_pkg::STATUS_SINGLE;
        end
        else
        begin
            status_next = smsd_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            mean_out_reg   <= mean_res_reg;
            sd_out_reg     <= sd_res_reg;
            status_out_reg <= status_next;
        end
    end

    assign mean_q8       = mean_out_reg;
    assign std_dev_q8    = sd_out_reg;
    assign status        = status_out_reg;
    assign sts.mul_done  = mul_done_reg;
    assign sts.div_done  = div_done;
    assign sts.root_done = root_done;
    assign sts.n_zero    = (count_reg == '0);
    assign sts.n_ge2     = (count_reg >= CW'(2));

endmodule

`default_nettype wire

@@ hw/rtl/smsd_ctrl.sv @@
// controller: accepts items, sequences the end-of-set arithmetic, owns the output valid
// depends on smsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module smsd_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           in_last,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output smsd_pkg::cmd_t      cmd,
    input  wire smsd_pkg::sts_t sts
);

    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_CHECK,
        ST_MUL_NQ,
        ST_MUL_SS,
        ST_MUL_NN,
        ST_DIV_MEAN,
        ST_DIV_SD,
        ST_ROOT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   start_reg;
    logic   start_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    always_comb
    begin
        in_ready     = (state_reg == ST_ACCUM);
        load         = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
        cmd.acc_en   = in_valid && in_ready;
        cmd.start    = start_reg;
        cmd.load_out = load;
        cmd.clear    = load;
        case (state_reg)
            ST_MUL_NQ:   cmd.op = smsd_pkg::OP_MUL_NQ;
            ST_MUL_SS:   cmd.op = smsd_pkg::OP_MUL_SS;
            ST_MUL_NN:   cmd.op = smsd_pkg::OP_MUL_NN;
            ST_DIV_MEAN: cmd.op = smsd_pkg::OP_DIV_MEAN;
            ST_DIV_SD:   cmd.op = smsd_pkg::OP_DIV_SD;
            ST_ROOT:     cmd.op = smsd_pkg::OP_ROOT;
            default:     cmd.op = smsd_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            ST_ACCUM:
            begin
                if (cmd.acc_en && in_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            // count now includes the last item
            ST_CHECK:
            begin
                if (sts.n_ge2)
                begin
                    state_next = ST_MUL_NQ;
                    start_next = 1'b1;
                end
                else if (!sts.n_zero)
                begin
                    state_next = ST_DIV_MEAN;
                    start_next = 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_MUL_NQ:
            begin
                if (sts.mul_done)
                begin
                    state_next = ST_MUL_SS;
                    start_next = 1'b1;
                end
            end
            ST_MUL_SS:
            begin
                if (sts.mul_done)
                begin
                    state_next = ST_MUL_NN;
                    start_next = 1'b1;
                end
            end
            ST_MUL_NN:
            begin
                if (sts.mul_done)
                begin
                    state_next = ST_DIV_MEAN;
                    start_next = 1'b1;
                end
            end
            ST_DIV_MEAN:
            begin
                if (sts.div_done)
                begin
                    if (sts.n_ge2)
                    begin
                        state_next = ST_DIV_SD;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV_SD:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_ROOT;
                    start_next = 1'b1;
                end
            end
            ST_ROOT:
            begin
                if (sts.root_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sample_mean_std_dev.sv @@
// top level of the sample mean and sample standard deviation block
// depends on smsd_pkg, smsd_ctrl and smsd_dp
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: score; tlast: last sample of the set
// m_axis    out  tvalid/tready          tdata: mean_q8, std_dev_q8; tuser: status
//
// samples are taken one per cycle while the set is open
// the item marked last closes the set: for sets of two or more samples, three
// shift-add multiplies, two restoring divides and a bitwise square root then run on
// one shared sequencer (a single sample runs only the mean divide), during which
// s_axis_tready is low
// a finished result waits in the output register; the next set may accumulate meanwhile
// rst_n clears the accumulators, the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none

module sample_mean_std_dev #(
    parameter int MAX_SAMPLES = smsd_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = smsd_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // [SAMPLE_BITS-1:0] score, upper bits zero
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  wire logic s_axis_tlast,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // [17:0] mean_q8, [35:18] std_dev_q8, upper bits zero
    output logic [smsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [smsd_pkg::STATUS_W-1:0]   m_axis_tuser
);

    localparam int OW    = smsd_pkg::OUT_W;
    localparam int PAD_W = smsd_pkg::OUT_DATA_W - 2 * OW;

    smsd_pkg::cmd_t cmd;
    smsd_pkg::sts_t sts;
    logic [OW-1:0]  mean_q8;
    logic [OW-1:0]  std_dev_q8;

    smsd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_last   (s_axis_tlast),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    smsd_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .score      (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cmd        (cmd),
        .sts        (sts),
        .mean_q8    (mean_q8),
        .std_dev_q8 (std_dev_q8),
        .status     (m_axis_tuser)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, std_dev_q8, mean_q8};

endmodule

`default_nettype wire
